[rtl/mse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared opcodes, status codes and item types for the MIPS subset executor.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_BEQ  = 4'd3;
  localparam logic [3:0] OP_BNE  = 4'd4;
  localparam logic [3:0] OP_SLT  = 4'd5;
  localparam logic [3:0] OP_J    = 4'd6;
  localparam logic [3:0] OP_LW   = 4'd7;
  localparam logic [3:0] OP_SW   = 4'd8;
  localparam logic [3:0] OP_ADDI = 4'd9;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_MEM = 2'd2;

  localparam logic [4:0] REG_SP = 5'd29;

  localparam int CODE_W = 21;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
    logic        use_base;
    logic [17:0] here;
    logic [17:0] target;
  } instr_t;

  typedef struct packed {
    logic alu;
    logic mul;
    logic slt;
    logic beq;
    logic bne;
    logic jmp;
    logic ld;
    logic st;
    logic skip;
  } iclass_t;

  typedef struct packed {
    instr_t  ins;
    iclass_t cls;
  } item_t;

endpackage

[rtl/mse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_front
// Accepts instruction transfers, classifies them and holds them in a
// two-entry queue for the execute side.
// ----------------------------------------------------------------------------
module mse_front
  import mse_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  instr_t in_ins,
  input  logic  hold,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  iclass_t    cls;
  logic       push;

  always_comb begin
    cls = '0;
    unique case (in_ins.op) inside
      OP_ADD, OP_SUB, OP_ADDI: cls.alu = 1'b1;
      OP_MUL:  cls.mul = 1'b1;
      OP_SLT:  cls.slt = 1'b1;
      OP_BEQ:  cls.beq = 1'b1;
      OP_BNE:  cls.bne = 1'b1;
      OP_J:    cls.jmp = 1'b1;
      OP_LW:   cls.ld  = 1'b1;
      OP_SW:   cls.st  = 1'b1;
      default: ;
    endcase
    // writes to register zero are skipped and only advance the index
    if (in_ins.rd == 5'd0 && (cls.alu || cls.mul || cls.slt || cls.ld)) begin
      cls = '0;
      cls.skip = 1'b1;
    end
  end

  assign in_ready = (cnt_r != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{ins: in_ins, cls: cls};
    end
  end

endmodule

[rtl/mse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_back
// Execute side: register file, data memory, ALU, multiplier and the result
// register. Sweeps the data memory to zero after reset.
// ----------------------------------------------------------------------------
module mse_back
  import mse_pkg::*;
#(
  parameter int MEM_BYTES = 1048576
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CODE_W-1:0] code_bytes,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clr_busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [18:0]       out_next,
  output logic [1:0]        out_status,
  output logic              out_wr,
  output logic [4:0]        out_idx,
  output logic [31:0]       out_val
);

  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int WADDR     = $clog2(MEM_WORDS);
  localparam logic [WADDR-1:0] LAST_WORD = WADDR'(MEM_WORDS - 1);
  localparam logic signed [34:0] ADDR_MAX = 35'(MEM_BYTES - 1);
  localparam logic [31:0] SP_RESET = 32'(MEM_BYTES);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_RD  = 3'd1;
  localparam logic [2:0] S_EX  = 3'd2;
  localparam logic [2:0] S_MUL = 3'd3;
  localparam logic [2:0] S_LD  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [WADDR-1:0] clr_r, clr_nxt;
  item_t            cur_r;
  logic [4:0]       rb_r;
  logic [31:0]      rfv_r;
  logic signed [63:0] prod_r;

  logic        ov_r, ov_nxt;
  logic [18:0] on_r, on_nxt;
  logic [1:0]  os_r, os_nxt;
  logic        ow_r, ow_nxt;
  logic [4:0]  oi_r, oi_nxt;
  logic [31:0] oval_r, oval_nxt;

  logic [31:0] rda, rdb, va, vb, dm_rdata;
  logic        rf_re, rf_we, dm_re, dm_we;
  logic [4:0]  rb_sel;
  logic [WADDR-1:0] dm_waddr;
  logic [31:0] dm_wdata;
  logic signed [63:0] prod_w;
  logic [32:0] sa, sb, sum;
  logic signed [34:0] addr;
  logic        bad, mul_ovf, out_free, fin, res_wr;
  logic [18:0] res_next;
  logic [1:0]  res_stat;
  logic [31:0] res_val;
  instr_t      ci;

  assign ci = cur_r.ins;

  assign rf_re  = (state_r == S_RD) && q_valid;
  assign q_pop  = rf_re;
  assign rb_sel = q_item.cls.st ? q_item.ins.rd : q_item.ins.rb;

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(ci.rd), .wdata(res_val),
    .re(rf_re), .raddr(q_item.ins.ra), .rdata(rda)
  );

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(ci.rd), .wdata(res_val),
    .re(rf_re), .raddr(rb_sel), .rdata(rdb)
  );

  mse_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(dm_re), .raddr(addr[WADDR+1:2]), .rdata(dm_rdata)
  );

  // never-written entries read as their reset value
  assign va = rfv_r[ci.ra] ? rda : ((ci.ra == REG_SP) ? SP_RESET : 32'd0);
  assign vb = rfv_r[rb_r]  ? rdb : ((rb_r == REG_SP) ? SP_RESET : 32'd0);

  assign prod_w = $signed(va) * $signed(vb);

  assign sa  = {va[31], va};
  assign sb  = (ci.op == OP_ADDI) ? {ci.imm[31], ci.imm} : {vb[31], vb};
  assign sum = (ci.op == OP_SUB) ? sa - sb : sa + sb;

  assign addr = $signed({14'd0, code_bytes}) + $signed({{3{ci.imm[31]}}, ci.imm})
              + (ci.use_base ? $signed({{3{va[31]}}, va}) : 35'sd0);
  assign bad  = (addr < $signed({14'd0, code_bytes})) || (addr > ADDR_MAX)
              || (addr[1:0] != 2'd0);

  assign mul_ovf  = !((&prod_r[63:31]) || !(|prod_r[63:31]));
  assign out_free = !ov_r || out_ready;
  assign clr_busy = (state_r == S_CLR);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    res_next  = {1'b0, ci.here} + 19'd1;
    res_stat  = STAT_OK;
    res_wr    = 1'b0;
    res_val   = 32'd0;
    fin       = 1'b0;
    dm_re     = 1'b0;
    dm_we     = 1'b0;
    dm_waddr  = addr[WADDR+1:2];
    dm_wdata  = vb;
    unique case (state_r)
      S_CLR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_r;
        dm_wdata = 32'd0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST_WORD) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (q_valid) begin
          state_nxt = S_EX;
        end
      end
      S_EX: begin
        fin = out_free;
        if (cur_r.cls.alu) begin
          if (sum[32] != sum[31]) begin
            res_stat = STAT_OVF;
          end else begin
            res_wr  = 1'b1;
            res_val = sum[31:0];
          end
        end else if (cur_r.cls.slt) begin
          res_wr  = 1'b1;
          res_val = {31'd0, $signed(va) < $signed(vb)};
        end else if (cur_r.cls.beq) begin
          if (va == vb) res_next = {1'b0, ci.target};
        end else if (cur_r.cls.bne) begin
          if (va != vb) res_next = {1'b0, ci.target};
        end else if (cur_r.cls.jmp) begin
          res_next = {1'b0, ci.target};
        end else if (cur_r.cls.mul) begin
          fin = 1'b0;
        end else if (cur_r.cls.ld || cur_r.cls.st) begin
          if (bad) begin
            res_stat = STAT_MEM;
          end else if (cur_r.cls.ld) begin
            fin   = 1'b0;
            dm_re = 1'b1;
          end else begin
            dm_we = out_free;
          end
        end
        if (cur_r.cls.mul) begin
          state_nxt = S_MUL;
        end else if (dm_re) begin
          state_nxt = S_LD;
        end else if (fin) begin
          state_nxt = S_RD;
        end
      end
      S_MUL: begin
        fin = out_free;
        if (mul_ovf) begin
          res_stat = STAT_OVF;
        end else begin
          res_wr  = 1'b1;
          res_val = prod_r[31:0];
        end
        if (fin) state_nxt = S_RD;
      end
      S_LD: begin
        fin     = out_free;
        res_wr  = 1'b1;
        res_val = dm_rdata;
        if (fin) state_nxt = S_RD;
      end
      default: state_nxt = S_RD;
    endcase
    rf_we = fin && res_wr;
  end

  always_comb begin
    ov_nxt   = ov_r && !out_ready;
    on_nxt   = on_r;
    os_nxt   = os_r;
    ow_nxt   = ow_r;
    oi_nxt   = oi_r;
    oval_nxt = oval_r;
    if (fin) begin
      ov_nxt   = 1'b1;
      on_nxt   = res_next;
      os_nxt   = res_stat;
      ow_nxt   = res_wr;
      oi_nxt   = res_wr ? ci.rd : 5'd0;
      oval_nxt = res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      rfv_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      if (rf_we) begin
        rfv_r[ci.rd] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    on_r   <= on_nxt;
    os_r   <= os_nxt;
    ow_r   <= ow_nxt;
    oi_r   <= oi_nxt;
    oval_r <= oval_nxt;
    if (rf_re) begin
      cur_r <= q_item;
      rb_r  <= rb_sel;
    end
    if (state_r == S_EX) begin
      prod_r <= prod_w;
    end
  end

  assign out_valid  = ov_r;
  assign out_next   = on_r;
  assign out_status = os_r;
  assign out_wr     = ow_r;
  assign out_idx    = oi_r;
  assign out_val    = oval_r;

endmodule

[rtl/mips_subset_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute
// Executes one decoded MIPS subset instruction per input transfer and
// returns one result transfer per instruction.
// ----------------------------------------------------------------------------
// Each instruction passes the register-file read state and then the execute
// and write-back state of the execute side; mul and an in-range lw add a
// state for the multiplier register or the data-memory read. A two-entry
// queue and a result register let input and output stall independently.
// After reset the data memory is swept to zero, word by word, during
// which in_tready stays low; code_bytes may be written at any time then.
module mips_subset_execute
  import mse_pkg::*;
#(
  parameter int MEM_BYTES = 1048576
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CODE_W-1:0] cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // operation[3:0], dest_reg[8:4], src_a[13:9], src_b[18:14], immediate[50:19],
  // use_base[51], this_index[69:52], target_index[87:70]
  input  logic [87:0]       in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // next_index[18:0], status[20:19], reg_written[21], reg_index[26:22],
  // reg_value[58:27], zero fill [63:59]
  output logic [63:0]       out_tdata
);

  logic [CODE_W-1:0] code_r;
  instr_t in_ins;
  item_t  q_item;
  logic   q_valid, q_pop, clr_busy;
  logic [18:0] o_next;
  logic [1:0]  o_stat;
  logic        o_wr;
  logic [4:0]  o_idx;
  logic [31:0] o_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else if (cfg_wr_en) begin
      code_r <= cfg_wr_data;
    end
  end

  assign in_ins = '{op: in_tdata[3:0], rd: in_tdata[8:4], ra: in_tdata[13:9],
                    rb: in_tdata[18:14], imm: in_tdata[50:19],
                    use_base: in_tdata[51], here: in_tdata[69:52],
                    target: in_tdata[87:70]};

  mse_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_ins(in_ins),
    .hold(clr_busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  mse_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .code_bytes(code_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .clr_busy(clr_busy),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_next(o_next), .out_status(o_stat), .out_wr(o_wr),
    .out_idx(o_idx), .out_val(o_val)
  );

  assign out_tdata = {5'd0, o_val, o_idx, o_wr, o_stat, o_next};

endmodule

[test/mse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_checker
// Watches the instruction and result streams of the MIPS subset executor,
// keeps its own register file and data memory, predicts each result and
// compares it field by field.
// ----------------------------------------------------------------------------
module mse_checker
  import mse_pkg::*;
#(
  parameter int MEM_BYTES = 1048576
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CODE_W-1:0] cfg_wr_data,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [87:0]       in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [63:0]       out_tdata,
  output int                fail_count,
  output int                pending
);

  localparam int EXP_DEPTH = 64;

  // lowest field last, so the layout matches out_tdata
  typedef struct packed {
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_written;
    logic [1:0]  status;
    logic [18:0] next_index;
  } exec_result_t;

  logic [31:0]       regs [32];
  logic [31:0]       dmem [MEM_BYTES/4];
  logic [CODE_W-1:0] code_bytes;
  exec_result_t      exp_fifo [EXP_DEPTH];
  int                exp_wr, exp_rd;

  assign pending = exp_wr - exp_rd;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  function automatic exec_result_t execute(input logic [87:0] d);
    exec_result_t r;
    logic [3:0]   op;
    logic [4:0]   rd, ra, rb;
    longint       imm, va, vb, res, addr;
    logic         ub, wr;
    logic [31:0]  wval;
    op   = d[3:0];
    rd   = d[8:4];
    ra   = d[13:9];
    rb   = d[18:14];
    imm  = longint'($signed(d[50:19]));
    ub   = d[51];
    va   = longint'($signed(regs[ra]));
    vb   = longint'($signed(regs[rb]));
    r    = '0;
    r.next_index = {1'b0, d[69:52]} + 19'd1;
    wr   = 1'b0;
    wval = '0;
    res  = 0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_ADDI: begin
        if (rd != 0) begin
          if (op == OP_ADD) res = va + vb;
          else if (op == OP_SUB) res = va - vb;
          else if (op == OP_MUL) res = va * vb;
          else res = va + imm;
          if (res > 64'sd2147483647 || res < -64'sd2147483648) r.status = STAT_OVF;
          else begin
            wr = 1'b1;
            wval = res[31:0];
          end
        end
      end
      OP_BEQ: if (va == vb) r.next_index = {1'b0, d[87:70]};
      OP_BNE: if (va != vb) r.next_index = {1'b0, d[87:70]};
      OP_SLT: begin
        if (rd != 0) begin
          wr = 1'b1;
          wval = (va < vb) ? 32'd1 : 32'd0;
        end
      end
      OP_J: r.next_index = {1'b0, d[87:70]};
      OP_LW, OP_SW: begin
        if (!(op == OP_LW && rd == 0)) begin
          addr = longint'(code_bytes) + imm + (ub ? va : 0);
          if (addr < longint'(code_bytes) || addr > MEM_BYTES - 1 || addr[1:0] != 0)
            r.status = STAT_MEM;
          else if (op == OP_LW) begin
            wr = 1'b1;
            wval = dmem[addr >> 2];
          end else dmem[addr >> 2] = regs[rd];
        end
      end
      default: ;
    endcase
    if (wr) begin
      regs[rd] = wval;
      r.reg_written = 1'b1;
      r.reg_index = rd;
      r.reg_value = wval;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    exec_result_t got, want;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = (i == REG_SP) ? 32'(MEM_BYTES) : 32'd0;
      code_bytes <= '0;
      fail_count = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (cfg_wr_en) code_bytes <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        exp_fifo[exp_wr % EXP_DEPTH] = execute(in_tdata);
        exp_wr++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[58:0];
        if (exp_wr == exp_rd) report_mismatch("unexpected result", 0, 0);
        else begin
          want = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got.next_index != want.next_index)
            report_mismatch("next_index", got.next_index, want.next_index);
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.reg_written != want.reg_written)
            report_mismatch("reg_written", got.reg_written, want.reg_written);
          if (got.reg_index != want.reg_index)
            report_mismatch("reg_index", got.reg_index, want.reg_index);
          if (got.reg_value != want.reg_value)
            report_mismatch("reg_value", got.reg_value, want.reg_value);
        end
      end
    end
  end

  initial begin
    foreach (dmem[i]) dmem[i] = '0;
  end

endmodule

[test/mips_subset_execute_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_tb
// Drives directed and random instruction streams into the executor under
// several code_bytes settings with random stalls on both sides; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module mips_subset_execute_tb;
  import mse_pkg::*;

  localparam int MEM_BYTES = 1048576;
  localparam int LIMIT = 3000000;

  logic              clk, rst_n;
  logic              cfg_wr_en;
  logic [CODE_W-1:0] cfg_wr_data;
  logic              in_tvalid, in_tready, out_tvalid, out_tready;
  logic [87:0]       in_tdata;
  logic [63:0]       out_tdata;
  int                fail_count, pending, cycles;
  logic              no_idle;

  mips_subset_execute #(.MEM_BYTES(MEM_BYTES)) dut (.*);

  mse_checker #(.MEM_BYTES(MEM_BYTES)) chk (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= no_idle || ($urandom_range(99) >= 13);

  function automatic logic [87:0] pack(input logic [3:0] op, input logic [4:0] rd,
      input logic [4:0] ra, input logic [4:0] rb, input logic [31:0] imm,
      input logic ub, input logic [17:0] here, input logic [17:0] tgt);
    return {tgt, here, ub, imm, rb, ra, rd, op};
  endfunction

  // Leaves tvalid high after the transfer; the next call or the caller drops it.
  task automatic send(input logic [87:0] d);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_config(input logic [CODE_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly small word-aligned offsets so lw/sw reach memory, with noise.
  task automatic random_item(input int cb);
    logic [3:0]  op;
    logic [31:0] imm;
    int          sel;
    op = 4'($urandom_range(15));
    if ($urandom_range(99) < 80) op = 4'($urandom_range(9));
    sel = $urandom_range(9);
    if (sel < 5) imm = $urandom_range(63) * 4;
    else if (sel < 7) imm = MEM_BYTES - cb - 4 * $urandom_range(2);
    else if (sel < 8) imm = $urandom_range(7) - 4;
    else imm = $urandom;
    send(pack(op, 5'($urandom_range(31)), 5'($urandom_range(31)),
              5'($urandom_range(31)), imm, 1'($urandom_range(1)),
              18'($urandom), 18'($urandom)));
  endtask

  initial begin
    int settings [4] = '{0, 1048576, 64, 2097151};
    cycles = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: load extremes, overflow, zero destination, branches, memory.
    send(pack(OP_ADDI, 1, 0, 0, 32'h7fffffff, 0, 0, 0));
    send(pack(OP_ADDI, 2, 0, 0, 32'h80000000, 0, 18'h3ffff, 0));
    send(pack(OP_ADD, 3, 1, 1, 0, 0, 2, 0));
    send(pack(OP_SUB, 3, 2, 1, 0, 0, 3, 0));
    send(pack(OP_MUL, 3, 1, 1, 0, 0, 4, 0));
    send(pack(OP_ADDI, 4, 0, 0, 32'hffffffff, 0, 5, 0));
    send(pack(OP_MUL, 5, 2, 4, 0, 0, 6, 0));
    send(pack(OP_MUL, 5, 1, 4, 0, 0, 7, 0));
    send(pack(OP_ADD, 0, 1, 1, 0, 0, 8, 0));
    send(pack(OP_SLT, 6, 2, 1, 0, 0, 9, 0));
    send(pack(OP_SLT, 0, 2, 1, 0, 0, 10, 0));
    send(pack(OP_BEQ, 0, 1, 1, 0, 0, 11, 18'h3ffff));
    send(pack(OP_BNE, 0, 1, 1, 0, 0, 12, 100));
    send(pack(OP_BNE, 0, 1, 2, 0, 0, 13, 100));
    send(pack(OP_J, 0, 0, 0, 0, 0, 14, 7));
    send(pack(OP_SW, 1, 29, 0, 32'hfffffffc, 1, 15, 0));
    send(pack(OP_LW, 7, 29, 0, 32'hfffffffc, 1, 16, 0));
    send(pack(OP_LW, 7, 29, 0, 0, 1, 17, 0));
    send(pack(OP_LW, 7, 0, 0, 2, 0, 18, 0));
    send(pack(OP_SW, 1, 0, 0, 32'hfffffffc, 0, 19, 0));
    send(pack(OP_LW, 0, 0, 0, 0, 0, 20, 0));
    send(pack(4'd15, 1, 1, 1, 0, 0, 21, 0));
    foreach (settings[s]) begin
      drain_and_config(CODE_W'(settings[s]));
      for (int i = 0; i < 250; i++) begin
        no_idle = (i >= 100 && i < 160);
        random_item(settings[s]);
      end
      no_idle = 1'b0;
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_front.sv
rtl/mse_back.sv
rtl/mips_subset_execute.sv
test/mse_checker.sv
test/mips_subset_execute_tb.sv
